// File: src/tbe_pkg.sv
// Shared types, constants and tables for the thresholded 3x3 binary erosion block.
// No dependencies; every other file except tbe_ram imports this package.
package tbe_pkg;

  // Frame limits and field widths
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int MIN_SIZE    = 3;
  localparam int SIZE_W      = 12;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int PIX_W       = 8;
  localparam int MASK_SEL_W  = 3;
  localparam int WIN_W       = 9;

  // Register file
  localparam int NUM_REGS    = 6;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int PADDR_W     = REG_IDX_W + 2;
  localparam int PDATA_W     = 32;

  // Front-to-back queue (depth must be a power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Structuring masks, bit row*3+col, row 0 on top, col 0 on the left
  localparam logic [WIN_W-1:0] MASK_TABLE [8] = '{
    9'h1FF,  // full 3x3
    9'h0BA,  // cross
    9'h038,  // horizontal line
    9'h092,  // vertical line
    9'h054,  // anti-diagonal
    9'h111,  // diagonal
    9'h007,  // top row
    9'h1C0   // bottom row
  };

  // Configuration as seen by the datapath, frame size already clamped
  typedef struct packed {
    logic [PIX_W-1:0]      threshold;
    logic [MASK_SEL_W-1:0] mask_select;
    logic [SIZE_W-1:0]     width;
    logic [SIZE_W-1:0]     height;
    logic [PIX_W-1:0]      low_level;
    logic [PIX_W-1:0]      high_level;
  } cfg_t;

  // One queued work word from front to back
  typedef struct packed {
    logic             is_pix;     // update window and line stores
    logic             bit_set;    // binarized pixel
    logic [COL_W-1:0] col;        // line store address
    logic             emit;       // produces a result
    logic             inner;      // result position is not on the border
    logic             frame_end;  // result is bottom right of the frame
  } item_t;

endpackage

// File: src/tbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module tbe_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/tbe_cfg.sv
// APB-style register file: threshold, mask, frame size and output levels.
// Depends on tbe_pkg for widths and the cfg_t bundle.
module tbe_cfg
  import tbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_MASK_SELECT  = 3'd1,
    REG_FRAME_WIDTH  = 3'd2,
    REG_FRAME_HEIGHT = 3'd3,
    REG_LOW_LEVEL    = 3'd4,
    REG_HIGH_LEVEL   = 3'd5
  } reg_idx_t;

  logic [PIX_W-1:0]      threshold_r,  threshold_nxt;
  logic [MASK_SEL_W-1:0] mask_sel_r,   mask_sel_nxt;
  logic [SIZE_W-1:0]     fwidth_r,     fwidth_nxt;
  logic [SIZE_W-1:0]     fheight_r,    fheight_nxt;
  logic [PIX_W-1:0]      low_r,        low_nxt;
  logic [PIX_W-1:0]      high_r,       high_nxt;
  logic                  wr_en;
  reg_idx_t              idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  // Decode the write
  always_comb begin
    threshold_nxt = threshold_r;
    mask_sel_nxt  = mask_sel_r;
    fwidth_nxt    = fwidth_r;
    fheight_nxt   = fheight_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    if (wr_en) begin
      case (idx)
        REG_THRESHOLD:    threshold_nxt = pwdata[PIX_W-1:0];
        REG_MASK_SELECT:  mask_sel_nxt  = pwdata[MASK_SEL_W-1:0];
        REG_FRAME_WIDTH:  fwidth_nxt    = pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: fheight_nxt   = pwdata[SIZE_W-1:0];
        REG_LOW_LEVEL:    low_nxt       = pwdata[PIX_W-1:0];
        REG_HIGH_LEVEL:   high_nxt      = pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= PIX_W'(204);
      mask_sel_r  <= '0;
      fwidth_r    <= SIZE_W'(640);
      fheight_r   <= SIZE_W'(480);
      low_r       <= '0;
      high_r      <= PIX_W'(255);
    end else begin
      threshold_r <= threshold_nxt;
      mask_sel_r  <= mask_sel_nxt;
      fwidth_r    <= fwidth_nxt;
      fheight_r   <= fheight_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
    end
  end

  // Read back raw register values
  always_comb begin
    case (idx)
      REG_THRESHOLD:    prdata = PDATA_W'(threshold_r);
      REG_MASK_SELECT:  prdata = PDATA_W'(mask_sel_r);
      REG_FRAME_WIDTH:  prdata = PDATA_W'(fwidth_r);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(fheight_r);
      REG_LOW_LEVEL:    prdata = PDATA_W'(low_r);
      REG_HIGH_LEVEL:   prdata = PDATA_W'(high_r);
      default:          prdata = '0;
    endcase
  end

  // Clamp frame size to the supported range
  always_comb begin
    cfg.threshold   = threshold_r;
    cfg.mask_select = mask_sel_r;
    cfg.low_level   = low_r;
    cfg.high_level  = high_r;
    if (fwidth_r < SIZE_W'(MIN_SIZE)) begin
      cfg.width = SIZE_W'(MIN_SIZE);
    end else if (fwidth_r > SIZE_W'(MAX_WIDTH)) begin
      cfg.width = SIZE_W'(MAX_WIDTH);
    end else begin
      cfg.width = fwidth_r;
    end
    if (fheight_r < SIZE_W'(MIN_SIZE)) begin
      cfg.height = SIZE_W'(MIN_SIZE);
    end else if (fheight_r > SIZE_W'(MAX_HEIGHT)) begin
      cfg.height = SIZE_W'(MAX_HEIGHT);
    end else begin
      cfg.height = fheight_r;
    end
  end

endmodule

// File: src/tbe_front.sv
// Front end: accepts items, binarizes, tracks input and output raster positions
// and decides which items produce a result. Depends on tbe_pkg.
module tbe_front
  import tbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [PIX_W-1:0] in_luma,
  input  logic             q_full,
  output logic             push,
  output item_t            push_item
);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pos_t;

  pos_t in_pos_r,  in_pos_nxt;
  pos_t out_pos_r, out_pos_nxt;
  pos_t in_cur, out_cur;
  logic accept, same, fwd, pix_emit, emit;
  logic [SIZE_W-1:0] ic_e, ir_e, oc_e, or_e, row_diff;

  // Step one raster position, wrapping at the frame edges
  function automatic pos_t step_pos(pos_t p, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    pos_t              q;
    logic [SIZE_W-1:0] c_inc;
    logic [SIZE_W-1:0] r_inc;
    c_inc = SIZE_W'(p.col) + SIZE_W'(1);
    r_inc = SIZE_W'(p.row) + SIZE_W'(1);
    q = p;
    if (c_inc >= w) begin
      q.col = '0;
      q.row = (r_inc >= h) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      q.col = c_inc[COL_W-1:0];
    end
    return q;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Restart positions that fall outside the current frame size
  always_comb begin
    in_cur  = in_pos_r;
    out_cur = out_pos_r;
    if (SIZE_W'(in_pos_r.col) >= cfg.width || SIZE_W'(in_pos_r.row) >= cfg.height) begin
      in_cur = '0;
    end
    if (SIZE_W'(out_pos_r.col) >= cfg.width || SIZE_W'(out_pos_r.row) >= cfg.height) begin
      out_cur = '0;
    end
  end

  assign ic_e = SIZE_W'(in_cur.col);
  assign ir_e = SIZE_W'(in_cur.row);
  assign oc_e = SIZE_W'(out_cur.col);
  assign or_e = SIZE_W'(out_cur.row);

  // Lag classification: rows apart and column difference, no multiply needed
  assign same     = (ic_e == oc_e) && (ir_e == or_e);
  assign fwd      = (ir_e > or_e) || ((ir_e == or_e) && (ic_e >= oc_e));
  assign row_diff = fwd ? (ir_e - or_e) : (ir_e + cfg.height - or_e);
  assign pix_emit = (row_diff >= SIZE_W'(2)) || ((row_diff == SIZE_W'(1)) && (ic_e > oc_e));
  assign emit     = in_op ? !same : pix_emit;

  // Advance positions on accept; write back wrapped values
  always_comb begin
    in_pos_nxt  = in_pos_r;
    out_pos_nxt = out_pos_r;
    if (accept) begin
      in_pos_nxt  = in_op ? in_cur : step_pos(in_cur, cfg.width, cfg.height);
      out_pos_nxt = emit ? step_pos(out_cur, cfg.width, cfg.height) : out_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pos_r  <= '0;
      out_pos_r <= '0;
    end else begin
      in_pos_r  <= in_pos_nxt;
      out_pos_r <= out_pos_nxt;
    end
  end

  // Build the work word; drop flushes that drain nothing
  assign push                = accept && (!in_op || emit);
  assign push_item.is_pix    = !in_op;
  assign push_item.bit_set   = in_luma > cfg.threshold;
  assign push_item.col       = in_cur.col;
  assign push_item.emit      = emit;
  assign push_item.inner     = (or_e >= SIZE_W'(1)) && ((or_e + SIZE_W'(1)) < cfg.height) &&
                               (oc_e >= SIZE_W'(1)) && ((oc_e + SIZE_W'(1)) < cfg.width);
  assign push_item.frame_end = ((or_e + SIZE_W'(1)) == cfg.height) &&
                               ((oc_e + SIZE_W'(1)) == cfg.width);

endmodule

// File: src/tbe_queue.sv
// Short FIFO of work words between front and back end.
// Depends on tbe_pkg for item_t and the queue depth.
module tbe_queue
  import tbe_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  empty
);

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: src/tbe_back.sv
// Back end: line store access, 3x3 window update, erosion and output register.
// Depends on tbe_pkg and instantiates tbe_ram for the two one-bit line stores.
module tbe_back
  import tbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  item_t            head,
  input  logic             q_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_out_pixel,
  output logic             out_frame_end
);

  logic             s1_valid_r, s1_valid_nxt;
  item_t            s1_item_r;
  logic [WIN_W-1:0] win_r, win_nxt, win_upd, win_cur, mask;
  logic [1:0]       ls_rd;            // {upper, middle} for the column
  logic             s1_adv, out_free, hit;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pixel_r, out_pixel_nxt;
  logic             out_fend_r,  out_fend_nxt;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_item_r.emit || out_free);
  assign pop      = !q_empty && (!s1_valid_r || s1_adv);

  // Both line stores share one address: bit 1 upper, bit 0 middle
  tbe_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_adv && s1_item_r.is_pix),
    .wr_addr (s1_item_r.col),
    .wr_data ({ls_rd[0], s1_item_r.bit_set}),
    .rd_en   (pop),
    .rd_addr (head.col),
    .rd_data (ls_rd)
  );

  // Shift the window left one column and insert the new column
  assign win_upd = {s1_item_r.bit_set, win_r[8:7], ls_rd[0], win_r[5:4], ls_rd[1], win_r[2:1]};
  assign win_cur = s1_item_r.is_pix ? win_upd : win_r;
  assign win_nxt = s1_adv ? win_cur : win_r;

  // Erode with the selected mask
  assign mask = MASK_TABLE[cfg.mask_select];
  assign hit  = s1_item_r.inner && ((win_cur & mask) == mask);

  // Load or drain the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pixel_nxt = out_pixel_r;
    out_fend_nxt  = out_fend_r;
    if (s1_adv && s1_item_r.emit) begin
      out_valid_nxt = 1'b1;
      out_pixel_nxt = hit ? cfg.high_level : cfg.low_level;
      out_fend_nxt  = s1_item_r.frame_end;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign s1_valid_nxt = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item_r <= head;
    end
    out_pixel_r <= out_pixel_nxt;
    out_fend_r  <= out_fend_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_out_pixel = out_pixel_r;
  assign out_frame_end = out_fend_r;

endmodule

// File: src/threshold_binary_erode_3x3.sv
// Top level of the thresholded 3x3 binary erosion block.
// Depends on tbe_pkg; instantiates tbe_cfg, tbe_front, tbe_queue and tbe_back.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_op, in_luma
//   out      output     out_valid / out_ready  out_out_pixel, out_frame_end
//   cfg      APB write  psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One item per clock sustained while out_ready takes the results; a result passes the
// queue slot, the registered line store read and the output register before it shows.
// The front takes items while the four-word queue has room, so it keeps
// accepting while a finished result waits on out_ready.
// rst_n is synchronous: positions, window, queue, valid flags and config registers clear;
// line stores are not cleared and are written before any inner pixel reads them.
module threshold_binary_erode_3x3
  import tbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [PIX_W-1:0]   in_luma,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_out_pixel,
  output logic               out_frame_end,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t  cfg;
  item_t push_item, head;
  logic  push, q_full, pop, q_empty;

  tbe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_luma   (in_luma),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  tbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  tbe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_out_pixel (out_out_pixel),
    .out_frame_end (out_frame_end)
  );

endmodule

// File: src/tbe_check.sv
// Port-level checker for threshold_binary_erode_3x3, attached by bind.
// Depends on tbe_pkg for port widths.
module tbe_check
  import tbe_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PIX_W-1:0]   out_out_pixel,
  input logic               out_frame_end,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  // Stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_pixel) && $stable(out_frame_end))
    else $error("result word changed while stalled");

  // Input backpressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Threshold reads back what was written
  a_thr_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == '0)
    |=> !psel || pwrite || (paddr[PADDR_W-1:2] != '0) ||
        (prdata == PDATA_W'($past(pwdata[PIX_W-1:0]))))
    else $error("threshold read back mismatch");

endmodule

bind threshold_binary_erode_3x3 tbe_check u_tbe_check (.*);

// File: tb/sv/erode_board_pkg.sv
// Scoreboard for the thresholded 3x3 erosion block: register shadow, line store
// and window predictor, and a queue of expected output words.
// Depends on tbe_pkg for widths and frame limits.
package erode_board_pkg;
  import tbe_pkg::*;

  typedef enum int {
    REG_THRESHOLD,
    REG_MASK_SELECT,
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_LOW_LEVEL,
    REG_HIGH_LEVEL
  } reg_index_e;

  typedef enum bit {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } word_op_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } eroded_word_t;

  // Structuring elements, bit row*3+col with row 0 on top and col 0 on the left
  localparam bit [8:0] ERODE_MASKS [8] = '{
    9'b111_111_111,  // full 3x3
    9'b010_111_010,  // cross
    9'b000_111_000,  // horizontal line
    9'b010_010_010,  // vertical line
    9'b001_010_100,  // anti-diagonal
    9'b100_010_001,  // diagonal
    9'b000_000_111,  // top row
    9'b111_000_000   // bottom row
  };

  class erode_board;
    logic [PIX_W-1:0]      threshold;
    logic [MASK_SEL_W-1:0] mask_select;
    logic [SIZE_W-1:0]     frame_width;
    logic [SIZE_W-1:0]     frame_height;
    logic [PIX_W-1:0]      low_level;
    logic [PIX_W-1:0]      high_level;
    bit [MAX_WIDTH-1:0]    two_rows_up;
    bit [MAX_WIDTH-1:0]    one_row_up;
    bit [8:0]              window;
    int unsigned           in_col, in_row, out_col, out_row;
    eroded_word_t          awaited[$];
    int unsigned           errors;

    function new();
      threshold    = 8'd204;
      mask_select  = '0;
      frame_width  = 12'd640;
      frame_height = 12'd480;
      low_level    = 8'd0;
      high_level   = 8'd255;
      two_rows_up  = '0;
      one_row_up   = '0;
      window       = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      errors  = 0;
    endfunction

    // Shadow a register write, keeping only the field bits
    function void write_register(reg_index_e idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_THRESHOLD:    threshold    = value[PIX_W-1:0];
        REG_MASK_SELECT:  mask_select  = value[MASK_SEL_W-1:0];
        REG_FRAME_WIDTH:  frame_width  = value[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height = value[SIZE_W-1:0];
        REG_LOW_LEVEL:    low_level    = value[PIX_W-1:0];
        REG_HIGH_LEVEL:   high_level   = value[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    // Pixels taken in but not yet put out, with stale positions wrapped to zero
    function int unsigned backlog();
      int unsigned w, h, ic, ir, oc, orw, in_idx, out_idx;
      w = clamp_dim(frame_width, MAX_WIDTH);
      h = clamp_dim(frame_height, MAX_HEIGHT);
      ic = in_col;
      ir = in_row;
      oc = out_col;
      orw = out_row;
      if (ic >= w || ir >= h) begin
        ic = 0;
        ir = 0;
      end
      if (oc >= w || orw >= h) begin
        oc = 0;
        orw = 0;
      end
      in_idx = ir * w + ic;
      out_idx = orw * w + oc;
      return (in_idx >= out_idx) ? in_idx - out_idx : in_idx + w * h - out_idx;
    endfunction

    function bit input_at_origin();
      return in_col == 0 && in_row == 0;
    endfunction

    // Queue the word at the output position and advance it
    function void emit_word(int unsigned w, int unsigned h);
      eroded_word_t word;
      bit inner;
      bit [8:0] m;
      inner = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
      m = ERODE_MASKS[mask_select];
      word.pixel = (inner && (window & m) == m) ? high_level : low_level;
      word.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
      awaited.push_back(word);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
        if (out_row >= h) out_row = 0;
      end
    endfunction

    // Predict one accepted input word; return 1 when it yields an output word
    function bit take_word(word_op_e op, logic [PIX_W-1:0] luma);
      int unsigned w, h, lag;
      bit set_bit, up_bit, mid_bit;
      w = clamp_dim(frame_width, MAX_WIDTH);
      h = clamp_dim(frame_height, MAX_HEIGHT);
      lag = backlog();
      if (in_col >= w || in_row >= h) begin
        in_col = 0;
        in_row = 0;
      end
      if (out_col >= w || out_row >= h) begin
        out_col = 0;
        out_row = 0;
      end
      if (op == OP_FLUSH) begin
        if (lag == 0) return 1'b0;
        emit_word(w, h);
        return 1'b1;
      end
      // shift the window left, bring in the new column from the line stores
      set_bit = luma > threshold;
      up_bit = two_rows_up[in_col];
      mid_bit = one_row_up[in_col];
      window = {set_bit, window[8], window[7], mid_bit, window[5], window[4],
                up_bit, window[2], window[1]};
      two_rows_up[in_col] = mid_bit;
      one_row_up[in_col] = set_bit;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      if (lag >= w + 1) begin
        emit_word(w, h);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Compare an output word with the oldest expected one
    function void check_word(logic [PIX_W-1:0] pixel, logic frame_end, longint unsigned stamp);
      eroded_word_t want;
      if (awaited.size() == 0) begin
        $display("%0d ns: unexpected word, actual pixel %0d frame_end %0b",
                 stamp, pixel, frame_end);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (pixel !== want.pixel) begin
        $display("%0d ns: out_pixel expected %0d actual %0d", stamp, want.pixel, pixel);
        errors++;
      end
      if (frame_end !== want.frame_end) begin
        $display("%0d ns: frame_end expected %0b actual %0b", stamp, want.frame_end, frame_end);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/sv/threshold_binary_erode_3x3_test.sv
// Top-level bench for threshold_binary_erode_3x3: drives pixel and flush words,
// programs the APB registers and checks every output word.
// Depends on tbe_pkg, erode_board_pkg and the block itself.
module threshold_binary_erode_3x3_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tbe_pkg::*;
  import erode_board_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_op     = 1'b0;
  logic [PIX_W-1:0]   in_luma   = '0;
  logic               out_ready = 1'b0;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic               in_ready;
  logic               out_valid;
  logic [PIX_W-1:0]   out_out_pixel;
  logic               out_frame_end;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  erode_board  board;
  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned words_taken = 0;

  threshold_binary_erode_3x3 uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_luma       (in_luma),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_out_pixel (out_out_pixel),
    .out_frame_end (out_frame_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic bit sender_waits();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 56;
      IDLE_BOTH:   return $urandom_range(0, 99) < 10;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 56;
      IDLE_BOTH:     return $urandom_range(0, 99) < 10;
      default:       return 1'b0;
    endcase
  endfunction

  // Check each accepted output word, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_word(out_out_pixel, out_frame_end, $time);
    end
    out_ready <= !receiver_stalls();
  end

  // Offer one word and hold it until accepted
  task automatic send_word(word_op_e op, logic [PIX_W-1:0] luma);
    bit produced;
    while (sender_waits()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_luma <= luma;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    produced = board.take_word(op, luma);
    if (produced || op == OP_PIXEL) words_taken++;
  endtask

  // APB write: setup, access, then back to idle
  task automatic cfg_write(reg_index_e idx, logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(int'(idx) * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.write_register(idx, value);
    @(posedge clk);
  endtask

  // Stop sending, wait for every expected word, then let the pipe empty
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Luma that lands above the threshold with the given chance in percent
  function automatic logic [PIX_W-1:0] gen_luma(int unsigned set_pct);
    logic [PIX_W-1:0] thr;
    thr = board.threshold;
    if ($urandom_range(0, 99) < set_pct && thr != 8'hFF)
      return PIX_W'($urandom_range(255, int'(thr) + 1));
    return PIX_W'($urandom_range(int'(thr), 0));
  endfunction

  // Send pixels up to the end of the current frame, with stray flushes mixed in
  task automatic feed_frame(int unsigned set_pct, int unsigned flush_pct);
    bit done;
    done = 1'b0;
    while (!done) begin
      if ($urandom_range(0, 99) < flush_pct) begin
        send_word(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
      end else begin
        send_word(OP_PIXEL, gen_luma(set_pct));
        done = board.input_at_origin();
      end
    end
  endtask

  // Flush until the frame tail is out
  task automatic drain_tail();
    while (board.backlog() != 0) send_word(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
  endtask

  // Program a full small-frame setting
  task automatic set_frame_config(int unsigned mask_pick);
    int unsigned thr_pick;
    logic [PIX_W-1:0] thr;
    thr_pick = $urandom_range(0, 7);
    thr = (thr_pick == 0) ? 8'd0 : (thr_pick == 1) ? 8'd255 : PIX_W'($urandom_range(0, 255));
    cfg_write(REG_THRESHOLD, PDATA_W'(thr));
    cfg_write(REG_MASK_SELECT, PDATA_W'(mask_pick));
    cfg_write(REG_FRAME_WIDTH, ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                           : $urandom_range(3, 12));
    cfg_write(REG_FRAME_HEIGHT, $urandom_range(3, 8));
    cfg_write(REG_LOW_LEVEL, $urandom_range(0, 255));
    cfg_write(REG_HIGH_LEVEL, $urandom_range(0, 255));
  endtask

  // Rewrite a few registers mid-frame, sizes out of range at times;
  // widths stay inside the line store columns already filled
  task automatic disturb_config();
    reg_index_e idx;
    logic [PDATA_W-1:0] value;
    repeat ($urandom_range(1, 3)) begin
      idx = reg_index_e'($urandom_range(0, NUM_REGS - 1));
      value = $urandom();
      if (idx == REG_FRAME_WIDTH)
        value[SIZE_W-1:0] = SIZE_W'($urandom_range(0, 16));
      if (idx == REG_FRAME_HEIGHT)
        value[SIZE_W-1:0] = ($urandom_range(0, 19) == 0) ? 12'hFFF
                                                         : SIZE_W'($urandom_range(0, 16));
      cfg_write(idx, value);
    end
  endtask

  function automatic int unsigned pick_density();
    case ($urandom_range(0, 2))
      0:       return 25;
      1:       return 75;
      default: return 95;
    endcase
  endfunction

  initial begin
    logic [PIX_W-1:0] probe_lumas [8] = '{8'd0, 8'd255, 8'd204, 8'd205,
                                          8'h55, 8'hAA, 8'd203, 8'd1};
    int unsigned phase;
    int unsigned mask_turn;
    int unsigned stop_at;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: lone flush, threshold edges, then drain row 0
    send_word(OP_FLUSH, 8'hFF);
    foreach (probe_lumas[i]) send_word(OP_PIXEL, probe_lumas[i]);
    drain_tail();
    send_word(OP_FLUSH, 8'h00);

    // Widest frame used later, height clamped up from zero; fills those columns
    wait_quiet();
    idle_mode = IDLE_SENDER;
    cfg_write(REG_THRESHOLD, 32'd0);
    cfg_write(REG_MASK_SELECT, 32'd0);
    cfg_write(REG_FRAME_WIDTH, 32'd48);
    cfg_write(REG_FRAME_HEIGHT, 32'd0);
    cfg_write(REG_LOW_LEVEL, 32'h5A);
    cfg_write(REG_HIGH_LEVEL, 32'hA5);
    feed_frame(90, 0);
    drain_tail();

    // Smallest frame, both sizes clamped up from zero
    wait_quiet();
    idle_mode = IDLE_RECEIVER;
    cfg_write(REG_THRESHOLD, 32'd255);
    cfg_write(REG_MASK_SELECT, 32'd7);
    cfg_write(REG_FRAME_WIDTH, 32'd0);
    cfg_write(REG_FRAME_HEIGHT, 32'd0);
    cfg_write(REG_LOW_LEVEL, 32'hFF);
    cfg_write(REG_HIGH_LEVEL, 32'h00);
    feed_frame(50, 0);
    drain_tail();

    // Random phases: mostly whole frames, some mid-frame register changes
    phase = 0;
    mask_turn = 0;
    stop_at = words_taken + 1100;
    while (words_taken < stop_at) begin
      wait_quiet();
      idle_mode = idle_mode_e'(phase % 4);
      if ($urandom_range(0, 9) < 7) begin
        set_frame_config(mask_turn % 8);
        mask_turn++;
        repeat ($urandom_range(1, 3))
          feed_frame(pick_density(), ($urandom_range(0, 3) == 0) ? 3 : 0);
        if ($urandom_range(0, 1) == 1) drain_tail();
      end else begin
        disturb_config();
        repeat ($urandom_range(5, 60)) begin
          if ($urandom_range(0, 4) == 0) send_word(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
          else send_word(OP_PIXEL, gen_luma(pick_density()));
        end
      end
      phase++;
    end

    wait_quiet();
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
